@@ design/bgc_pkg.sv @@
// package: constants and types for the bipartite graph check
`timescale 1ns / 1ps
package bgc_pkg;
    localparam int MaxVertices = 64;
    localparam int MaxEdges    = 256;
    localparam int VW = $clog2(MaxVertices);
    localparam int EW = $clog2(MaxEdges);

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_RANGE = 2'd1;
    localparam logic [1:0] ERR_FULL  = 2'd2;

    localparam logic [1:0] COL_NONE = 2'd2;

    typedef enum logic [2:0] {
        B_IDLE, B_SCAN, B_POP, B_VERT, B_EDGE, B_TEST, B_DONE
    } back_state_t;

    // command from front to back: one completed graph
    typedef struct packed {
        logic [1:0]  err;
        logic [EW:0] total;
        logic [6:0]  nvert;
    } job_t;
endpackage

@@ design/bgc_if.sv @@
// handshake interfaces for edge items and result items
`timescale 1ns / 1ps
interface bgc_edge_if;
    logic       valid;
    logic       ready;
    logic [5:0] edge_from;
    logic [5:0] edge_to;
    logic       edge_present;
    logic       last_edge;
    modport source (output valid, edge_from, edge_to, edge_present, last_edge, input ready);
    modport sink (input valid, edge_from, edge_to, edge_present, last_edge, output ready);
endinterface

interface bgc_result_if;
    logic       valid;
    logic       ready;
    logic       is_bipartite;
    logic [1:0] error_code;
    modport source (output valid, is_bipartite, error_code, input ready);
    modport sink (input valid, is_bipartite, error_code, output ready);
endinterface

@@ design/bgc_front.sv @@
// front: takes edge items, checks them, writes the edge store, posts jobs
`timescale 1ns / 1ps
module bgc_front
    import bgc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    bgc_edge_if.sink     in_ch,
    input  logic [6:0]   vertex_count,
    input  logic         back_busy,
    output logic         wr_en,
    output logic [EW-1:0] wr_addr,
    output logic [2*VW-1:0] wr_data,
    output logic         job_valid,
    output job_t         job
);
    logic [EW:0] total_reg, total_next;
    logic [1:0]  err_reg, err_next;
    logic        pend_reg, pend_next;
    job_t        job_reg, job_next;
    logic [6:0]  n_eff;
    logic        bad, full, acc;

    always_comb
    begin
        if (vertex_count == 7'd0)
            n_eff = 7'd1;
        else if (vertex_count > 7'(MaxVertices))
            n_eff = 7'(MaxVertices);
        else
            n_eff = vertex_count;
    end

    // the store is owned by the back while a job is outstanding
    assign in_ch.ready = !pend_reg && !back_busy;
    assign acc  = in_ch.valid && in_ch.ready;
    assign bad  = ({1'b0, in_ch.edge_from} >= n_eff) || ({1'b0, in_ch.edge_to} >= n_eff);
    assign full = total_reg >= (EW+1)'(MaxEdges);
    assign wr_en   = acc && in_ch.edge_present && !bad && !full;
    assign wr_addr = total_reg[EW-1:0];
    assign wr_data = {in_ch.edge_from, in_ch.edge_to};
    assign job_valid = pend_reg;
    assign job = job_reg;

    always_comb
    begin
        total_next = total_reg;
        err_next   = err_reg;
        pend_next  = pend_reg;
        job_next   = job_reg;
        if (pend_reg && back_busy)
            pend_next = 1'b0;
        if (acc)
        begin
            if (in_ch.edge_present)
            begin
                if (bad)
                begin
                    if (err_next == ERR_NONE)
                        err_next = ERR_RANGE;
                end
                else if (full)
                begin
                    if (err_next == ERR_NONE)
                        err_next = ERR_FULL;
                end
                else
                    total_next = total_reg + 1'b1;
            end
            if (in_ch.last_edge)
            begin
                job_next.err   = err_next;
                job_next.total = total_next;
                job_next.nvert = n_eff;
                pend_next  = 1'b1;
                total_next = '0;
                err_next   = ERR_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            err_reg   <= ERR_NONE;
            pend_reg  <= 1'b0;
            job_reg   <= '0;
        end
        else
        begin
            total_reg <= total_next;
            err_reg   <= err_next;
            pend_reg  <= pend_next;
            job_reg   <= job_next;
        end
    end
endmodule

@@ design/bgc_back.sv @@
// back: two-colors the stored graph with a stack walk and gives the result
`timescale 1ns / 1ps
module bgc_back
    import bgc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  logic [EW-1:0] wr_addr,
    input  logic [2*VW-1:0] wr_data,
    input  logic         job_valid,
    input  job_t         job,
    output logic         busy,
    bgc_result_if.source out_ch
);
    logic [2*VW-1:0] edge_mem [MaxEdges];
    logic [VW:0]     stack_mem [MaxVertices];
    logic            color_mem [MaxVertices];
    logic [2*VW-1:0] rd_data;
    logic [VW:0]     stk_data;
    logic            col_data;
    logic [MaxVertices-1:0] seen_reg, seen_next;

    back_state_t st_reg, st_next;
    job_t        job_reg, job_next;
    logic [6:0]  i_reg, i_next;
    logic [EW:0] e_reg, e_next;
    logic [VW:0] sp_reg, sp_next;
    logic [VW-1:0] v_reg, v_next;
    logic        cv_reg, cv_next;
    logic        ov_reg, ov_next;
    logic        res_reg, res_next;
    logic        obip_reg, obip_next;
    logic [1:0]  oerr_reg, oerr_next;

    logic          col_we;
    logic [VW-1:0] col_addr;
    logic          col_val;
    logic          push;
    logic [VW:0]   push_v;
    logic [VW-1:0] stk_addr;
    logic [EW-1:0] rd_addr;
    logic [VW-1:0] ea, eb, w;
    logic          hit;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            edge_mem[wr_addr] <= wr_data;
        rd_data <= edge_mem[rd_addr];
        if (push)
            stack_mem[sp_reg[VW-1:0]] <= push_v;
        stk_data <= stack_mem[stk_addr];
        if (col_we)
            color_mem[col_addr] <= col_val;
        col_data <= color_mem[col_addr];
    end

    assign busy = (st_reg != B_IDLE);
    assign out_ch.valid = ov_reg;
    assign out_ch.is_bipartite = obip_reg;
    assign out_ch.error_code = oerr_reg;

    // stack entries hold the color in the top bit
    assign stk_addr = sp_reg[VW-1:0] - 1'b1;

    assign ea  = rd_data[2*VW-1:VW];
    assign eb  = rd_data[VW-1:0];
    assign w   = (ea == v_reg) ? eb : ea;
    assign hit = (ea == v_reg) || (eb == v_reg);

    always_comb
    begin
        st_next   = st_reg;
        job_next  = job_reg;
        i_next    = i_reg;
        e_next    = e_reg;
        sp_next   = sp_reg;
        v_next    = v_reg;
        cv_next   = cv_reg;
        ov_next   = ov_reg;
        res_next  = res_reg;
        obip_next = obip_reg;
        oerr_next = oerr_reg;
        seen_next = seen_reg;
        col_we    = 1'b0;
        col_addr  = w;
        col_val   = 1'b0;
        push      = 1'b0;
        push_v    = {cv_reg ^ 1'b1, w};
        rd_addr   = e_reg[EW-1:0];
        if (ov_reg && out_ch.ready)
            ov_next = 1'b0;
        case (st_reg)
            B_IDLE:
            begin
                if (job_valid)
                begin
                    job_next  = job;
                    i_next    = '0;
                    seen_next = '0;
                    st_next   = (job.err != ERR_NONE) ? B_DONE : B_SCAN;
                    res_next  = 1'b0;
                end
            end
            B_SCAN:
            begin
                if (i_reg >= job_reg.nvert)
                begin
                    res_next = 1'b1;
                    st_next  = B_DONE;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                    if (!seen_reg[i_reg[VW-1:0]])
                    begin
                        seen_next[i_reg[VW-1:0]] = 1'b1;
                        col_we   = 1'b1;
                        col_addr = i_reg[VW-1:0];
                        col_val  = 1'b0;
                        push     = 1'b1;
                        push_v   = {1'b0, i_reg[VW-1:0]};
                        sp_next  = sp_reg + 1'b1;
                        st_next  = B_POP;
                    end
                end
            end
            B_POP:
            begin
                // top of stack is read here and lands in stk_data
                if (sp_reg == '0)
                    st_next = B_SCAN;
                else
                begin
                    sp_next = sp_reg - 1'b1;
                    st_next = B_VERT;
                end
            end
            B_VERT:
            begin
                v_next  = stk_data[VW-1:0];
                cv_next = stk_data[VW];
                e_next  = '0;
                rd_addr = '0;
                st_next = B_EDGE;
            end
            B_EDGE:
            begin
                // rd_data holds edge e_reg, read issued last cycle
                if (e_reg >= job_reg.total)
                    st_next = B_POP;
                else if (hit)
                    st_next = B_TEST;
                else
                begin
                    e_next  = e_reg + 1'b1;
                    rd_addr = e_next[EW-1:0];
                end
            end
            B_TEST:
            begin
                // col_data holds the color of w, valid when w is seen
                if (seen_reg[w] && (col_data == cv_reg))
                begin
                    res_next = 1'b0;
                    sp_next  = '0;
                    st_next  = B_DONE;
                end
                else
                begin
                    if (!seen_reg[w])
                    begin
                        seen_next[w] = 1'b1;
                        col_we  = 1'b1;
                        col_val = cv_reg ^ 1'b1;
                        if (sp_reg < (VW+1)'(MaxVertices))
                        begin
                            push    = 1'b1;
                            sp_next = sp_reg + 1'b1;
                        end
                    end
                    e_next  = e_reg + 1'b1;
                    rd_addr = e_next[EW-1:0];
                    st_next = B_EDGE;
                end
            end
            B_DONE:
            begin
                if (!ov_reg)
                begin
                    ov_next   = 1'b1;
                    obip_next = res_reg;
                    oerr_next = job_reg.err;
                    st_next   = B_IDLE;
                end
            end
            default: st_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= B_IDLE;
            ov_reg   <= 1'b0;
            sp_reg   <= '0;
            seen_reg <= '0;
            obip_reg <= 1'b0;
            oerr_reg <= ERR_NONE;
        end
        else
        begin
            st_reg   <= st_next;
            ov_reg   <= ov_next;
            sp_reg   <= sp_next;
            seen_reg <= seen_next;
            obip_reg <= obip_next;
            oerr_reg <= oerr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        i_reg   <= i_next;
        e_reg   <= e_next;
        v_reg   <= v_next;
        cv_reg  <= cv_next;
        res_reg <= res_next;
    end
endmodule

@@ design/bipartite_graph_check_top.sv @@
// top level of the bipartite graph check
`timescale 1ns / 1ps
// Edge items load one per cycle, while no graph is pending or being walked,
// into a 256-entry edge store. The item marked last hands the graph to the
// walk engine, which clears its colored flags as it takes the graph and then
// two-colors each component with a stack walk: each popped vertex is fetched
// from the stack (pop state, then vertex state), then every stored edge is
// scanned from the edge memory read port, with an extra test state for each
// edge that touches it to read the neighbor's color. A graph with an error
// skips the walk and gives its result without scanning any edges. Input items
// are held off from the last item until the engine has posted its result to
// the output register; the result sits there until taken, and the next graph
// can load while it waits.
module bipartite_graph_check_top
    import bgc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    bgc_edge_if.sink     in_ch,
    bgc_result_if.source out_ch,
    input  logic         cfg_we,
    input  logic [6:0]   cfg_wdata
);
    logic [6:0]  vc_reg;
    logic        busy, wr_en, job_valid;
    logic [EW-1:0] wr_addr;
    logic [2*VW-1:0] wr_data;
    job_t        job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vc_reg <= 7'd64;
        else if (cfg_we)
            vc_reg <= cfg_wdata;
    end

    bgc_front u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .vertex_count(vc_reg),
        .back_busy(busy), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .job_valid(job_valid), .job(job)
    );

    bgc_back u_back (
        .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_addr(wr_addr),
        .wr_data(wr_data), .job_valid(job_valid), .job(job), .busy(busy),
        .out_ch(out_ch)
    );
endmodule
